>>> sv/assert_macros.svh
// Assertion macros for the checker file of the character table.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define CMSWS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold through reset.
`define CMSWS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cmsws_pkg.sv
// Shared types and constants for the character table with search.
// No dependencies; compile before every other file of the block.
package cmsws_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int ACT_W  = 2;
  localparam int SYM_W  = 8;
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int ROWS_W = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [SYM_W-1:0]   symbol;
    logic               row_last;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   found_row;
    logic [IDX_W-1:0]   found_col;
    logic [SYM_W-1:0]   read_value;
    logic               row_committed;
    logic [ROWS_W-1:0]  rows_used;
  } out_word_t;

endpackage

>>> sv/char_matrix_store_with_search.sv
// Top level of the character table: row append, element read, clear and linear find.
// Depends on cmsws_pkg and cmsws_ram.
//
//   channel   ports                      flow control
//   input     start, busy, in_word       taken when start is high and busy is low
//   result    out_strobe, out_word       one cycle per word, cannot be held off
//   config    cfg_we, cfg_wdata          written on any edge with cfg_we high, out of reset
//
// Append and clear: the result shows the cycle after the word is taken and busy stays low.
// A read passes through the registered RAM read, then ST_READ and the output register. A find
// inspects up to rows_used * min(cols_in_use, MAX_COLS) cells, one at a time, as the
// single RAM port yields one cell a cycle. Reset clears state, counters, column config and
// strobe only; the cell RAM holds no reset value and needs no clearing pass.
module char_matrix_store_with_search #(
  parameter int MAX_ROWS = cmsws_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = cmsws_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  cmsws_pkg::in_word_t             in_word,
  output logic                            out_strobe,
  output cmsws_pkg::out_word_t            out_word,
  input  logic                            cfg_we,
  input  logic [cmsws_pkg::CFG_W-1:0]     cfg_wdata
);
  import cmsws_pkg::*;

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int PEND_W = $clog2(MAX_COLS + 2);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W1A    = (PEND_W > CFG_W) ? PEND_W : CFG_W;
  localparam int W1     = ((W1A > IDX_W) ? W1A : IDX_W) + 1;
  localparam int W2     = ((RCNT_W > IDX_W) ? RCNT_W : IDX_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  state_t            state_r,   state_nxt;
  logic [RCNT_W-1:0] rows_r,    rows_nxt;
  logic [PEND_W-1:0] pend_r,    pend_nxt;
  logic [CFG_W-1:0]  cols_r;
  logic              strobe_r,  strobe_nxt;
  out_word_t         out_r,     out_nxt;
  logic [RW-1:0]     iss_row_r, iss_row_nxt;
  logic [CW-1:0]     iss_col_r, iss_col_nxt;
  logic [RW-1:0]     cmp_row_r, cmp_row_nxt;
  logic [CW-1:0]     cmp_col_r, cmp_col_nxt;
  logic [SYM_W-1:0]  sym_r,     sym_nxt;
  logic              rd_ok_r,   rd_ok_nxt;

  logic              accept;
  logic [W1-1:0]     scan_cols;
  logic              room;
  logic              store_char;
  logic [PEND_W-1:0] pend_inc;
  logic              commit;
  logic              cmp_col_end;
  logic              cmp_last;
  logic              iss_col_end;
  logic              ram_we;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     iss_addr;
  logic [AW-1:0]     ram_addr;
  logic [SYM_W-1:0]  ram_rdata;

  assign accept    = start && (state_r == ST_IDLE);
  assign scan_cols = (W1'(cols_r) < W1'(MAX_COLS)) ? W1'(cols_r) : W1'(MAX_COLS);
  assign room      = W2'(rows_r) < W2'(MAX_ROWS);
  assign store_char = room && (W1'(pend_r) < W1'(MAX_COLS));
  assign pend_inc  = (W1'(pend_r) <= W1'(MAX_COLS)) ? pend_r + PEND_W'(1) : pend_r;
  assign commit    = room && (W1'(cols_r) <= W1'(MAX_COLS)) &&
                     (W1'(pend_inc) == W1'(cols_r));

  // Scan bookkeeping: the compare stage trails the issue stage by one RAM read.
  assign cmp_col_end = (W1'(cmp_col_r) + W1'(1)) == scan_cols;
  assign cmp_last    = cmp_col_end && ((W2'(cmp_row_r) + W2'(1)) == W2'(rows_r));
  assign iss_col_end = (W1'(iss_col_r) + W1'(1)) == scan_cols;

  assign wr_addr  = AW'(RW'(rows_r)) * AW'(MAX_COLS) + AW'(CW'(pend_r));
  assign rd_addr  = AW'(RW'(in_word.row_index)) * AW'(MAX_COLS) + AW'(CW'(in_word.col_index));
  assign iss_addr = AW'(iss_row_r) * AW'(MAX_COLS) + AW'(iss_col_r);

  assign ram_we = accept && (in_word.action == ACT_APPEND) && store_char;

  always_comb begin
    if (ram_we) begin
      ram_addr = wr_addr;
    end else if (state_r == ST_SCAN) begin
      ram_addr = iss_addr;
    end else if (in_word.action == ACT_FIND) begin
      ram_addr = '0;
    end else begin
      ram_addr = rd_addr;
    end
  end

  cmsws_ram #(
    .WIDTH (SYM_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_word.symbol),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    rows_nxt    = rows_r;
    pend_nxt    = pend_r;
    strobe_nxt  = 1'b0;
    out_nxt     = '0;
    iss_row_nxt = iss_row_r;
    iss_col_nxt = iss_col_r;
    cmp_row_nxt = cmp_row_r;
    cmp_col_nxt = cmp_col_r;
    sym_nxt     = sym_r;
    rd_ok_nxt   = rd_ok_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.action)
            ACT_APPEND: begin
              pend_nxt = pend_inc;
              if (in_word.row_last) begin
                pend_nxt = '0;
                if (commit) begin
                  rows_nxt = rows_r + RCNT_W'(1);
                  out_nxt.row_committed = 1'b1;
                end
              end
              out_nxt.rows_used = ROWS_W'(rows_nxt);
              strobe_nxt = 1'b1;
            end
            ACT_FIND: begin
              sym_nxt = in_word.symbol;
              if ((rows_r == '0) || (scan_cols == '0)) begin
                out_nxt.rows_used = ROWS_W'(rows_r);
                strobe_nxt = 1'b1;
              end else begin
                state_nxt   = ST_SCAN;
                cmp_row_nxt = '0;
                cmp_col_nxt = '0;
                if (scan_cols == W1'(1)) begin
                  iss_row_nxt = RW'(1);
                  iss_col_nxt = '0;
                end else begin
                  iss_row_nxt = '0;
                  iss_col_nxt = CW'(1);
                end
              end
            end
            ACT_READ: begin
              rd_ok_nxt = (W2'(in_word.row_index) < W2'(rows_r)) &&
                          (W1'(in_word.col_index) < scan_cols);
              state_nxt = ST_READ;
            end
            ACT_CLEAR: begin
              rows_nxt   = '0;
              pend_nxt   = '0;
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_rdata == sym_r) begin
          out_nxt.found     = 1'b1;
          out_nxt.found_row = IDX_W'(cmp_row_r);
          out_nxt.found_col = IDX_W'(cmp_col_r);
          out_nxt.rows_used = ROWS_W'(rows_r);
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (cmp_last) begin
          out_nxt.rows_used = ROWS_W'(rows_r);
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          // advance: compare stage takes the issued cell, issue moves one cell on
          cmp_row_nxt = iss_row_r;
          cmp_col_nxt = iss_col_r;
          if (iss_col_end) begin
            iss_col_nxt = '0;
            iss_row_nxt = iss_row_r + RW'(1);
          end else begin
            iss_col_nxt = iss_col_r + CW'(1);
          end
        end
      end
      ST_READ: begin
        out_nxt.read_value = rd_ok_r ? ram_rdata : '0;
        out_nxt.rows_used  = ROWS_W'(rows_r);
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rows_r   <= '0;
      pend_r   <= '0;
      cols_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rows_r   <= rows_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        cols_r <= cfg_wdata;
      end
    end
    out_r     <= out_nxt;
    iss_row_r <= iss_row_nxt;
    iss_col_r <= iss_col_nxt;
    cmp_row_r <= cmp_row_nxt;
    cmp_col_r <= cmp_col_nxt;
    sym_r     <= sym_nxt;
    rd_ok_r   <= rd_ok_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_word   = out_r;

endmodule

>>> sv/cmsws_ram.sv
// Generic single-port RAM with a registered read, one access per cycle.
// Depends on cmsws_pkg for its default sizes only.
module cmsws_ram #(
  parameter int WIDTH = cmsws_pkg::SYM_W,
  parameter int DEPTH = cmsws_pkg::MAX_ROWS_DEF * cmsws_pkg::MAX_COLS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/cmsws_chk.sv
// Port-level checker for the character table, bound to the top level.
// Depends on cmsws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmsws_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input cmsws_pkg::in_word_t         in_word,
  input logic                        out_strobe,
  input cmsws_pkg::out_word_t        out_word
);
  import cmsws_pkg::*;

  logic take;
  logic quick_act;
  logic read_act;
  logic clear_act;
  logic miss_pos_zero;
  logic empty_word;

  assign take          = start && !busy;
  assign quick_act     = in_word.action inside {ACT_APPEND, ACT_CLEAR};
  assign read_act      = (in_word.action == ACT_READ);
  assign clear_act     = (in_word.action == ACT_CLEAR);
  assign miss_pos_zero = (out_word.found_row == '0) && (out_word.found_col == '0);
  assign empty_word    = (out_word.rows_used == '0) && !out_word.row_committed;

  `CMSWS_ASSERT(a_quick_word, clk, rst_n, take && quick_act |=> out_strobe && !busy, "append or clear gave no word")

  `CMSWS_ASSERT(a_read_latency, clk, rst_n, take && read_act |=> busy ##1 out_strobe, "read not done in two cycles")

  `CMSWS_ASSERT(a_miss_zero, clk, rst_n, out_strobe && !out_word.found |-> miss_pos_zero, "miss carries a position")

  `CMSWS_ASSERT(a_clear_empties, clk, rst_n, take && clear_act |=> empty_word, "clear left rows in use")

  `CMSWS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_strobe && !busy, "result or busy after reset")

endmodule

bind char_matrix_store_with_search cmsws_chk u_cmsws_chk (.*);
